/* src/ccal_pkg.sv */
// Shared constants, codes and types for the contiguous cell allocator.
package ccal_pkg;

    // Default sizes
    localparam int CELLS_DEF   = 256;
    localparam int ID_BITS_DEF = 8;

    // Fixed field widths
    localparam int STATUS_W  = 2;
    localparam int POL_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int RUNS_W    = 32;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POL_W-1:0] POL_WORST = 2'd3;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_USE = 1'd1;

    // Operations of the shared scan unit
    typedef enum logic [1:0] {
        SM_LARGEST,
        SM_SMALLEST,
        SM_RUN,
        SM_HOLE
    } scan_mode_t;

    // Per-cycle control from the sequencer to the scan unit
    typedef struct packed {
        logic       init;
        logic       clr_acc;
        logic       step;
        logic       cell_free;
        scan_mode_t mode;
    } scan_ctrl_t;

endpackage

/* src/ccal_if.sv */
// Request and response channel interfaces of the contiguous cell allocator.
interface ccal_req_if #(
    parameter int ID_BITS = ccal_pkg::ID_BITS_DEF,
    parameter int CW      = 9
) ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ID_BITS-1:0] owner_id;
    logic [CW-1:0]      run_length;

    modport source (output valid, kind, owner_id, run_length, input ready);
    modport sink   (input valid, kind, owner_id, run_length, output ready);
endinterface

interface ccal_rsp_if #(
    parameter int CB = 8,
    parameter int CW = 9
) ();
    logic                         valid;
    logic                         ready;
    logic [ccal_pkg::STATUS_W-1:0] status;
    logic [CB-1:0]                start_cell;
    logic [CW-1:0]                largest_hole;
    logic [CW-1:0]                occupied_cells;
    logic [CW-1:0]                owner_count;

    modport source (output valid, status, start_cell, largest_hole, occupied_cells,
                    owner_count, input ready);
    modport sink   (input valid, status, start_cell, largest_hole, occupied_cells,
                    owner_count, output ready);
endinterface

/* src/ccal_store.sv */
// Cell owner memory: one write port, one registered read port.
module ccal_store #(
    parameter int CELLS   = ccal_pkg::CELLS_DEF,
    parameter int ID_BITS = ccal_pkg::ID_BITS_DEF,
    localparam int CB     = $clog2(CELLS)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [CB-1:0]      wr_addr,
    input  logic [ID_BITS-1:0] wr_data,
    input  logic               rd_en,
    input  logic [CB-1:0]      rd_addr,
    output logic [ID_BITS-1:0] rd_data
);
    logic [ID_BITS-1:0] mem [CELLS];
    logic [ID_BITS-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* src/ccal_scan.sv */
// Shared scan unit: free-run counter and one set of compares, stepped over the cells one at a time.
module ccal_scan #(
    parameter int CELLS = ccal_pkg::CELLS_DEF,
    localparam int CB   = $clog2(CELLS),
    localparam int CW   = $clog2(CELLS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccal_pkg::scan_ctrl_t ctrl,
    input  logic [CW-1:0]        pos,
    input  logic [CW-1:0]        len,
    output logic [CW-1:0]        acc,
    output logic                 found,
    output logic [CB-1:0]        start
);
    import ccal_pkg::*;

    localparam logic [CW-1:0] ONE_W = CW'(1);

    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic          found_reg, found_next;
    logic [CB-1:0] start_reg, start_next;
    logic [CW-1:0] run_inc;
    logic          hole_end;
    logic [CW-1:0] run_start;
    logic [CW-1:0] hole_start;

    assign run_inc    = run_reg + ONE_W;
    assign hole_end   = !ctrl.cell_free && (run_reg != '0);
    assign run_start  = pos + ONE_W - len;
    assign hole_start = pos - run_reg;

    // One cell per step
    always_comb
    begin
        run_next   = run_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        start_next = start_reg;
        if (ctrl.init)
        begin
            run_next   = '0;
            found_next = 1'b0;
            if (ctrl.clr_acc)
            begin
                acc_next = '0;
            end
        end
        else if (ctrl.step)
        begin
            unique case (ctrl.mode)
                SM_LARGEST:
                begin
                    if (ctrl.cell_free && (run_inc > acc_reg))
                    begin
                        acc_next = run_inc;
                    end
                end
                SM_SMALLEST:
                begin
                    if (hole_end && (run_reg >= len) && (run_reg < acc_reg))
                    begin
                        acc_next = run_reg;
                    end
                end
                SM_RUN:
                begin
                    if (!found_reg && ctrl.cell_free && (run_inc == len))
                    begin
                        found_next = 1'b1;
                        start_next = run_start[CB-1:0];
                    end
                end
                SM_HOLE:
                begin
                    if (!found_reg && hole_end && (run_reg == acc_reg))
                    begin
                        found_next = 1'b1;
                        start_next = hole_start[CB-1:0];
                    end
                end
            endcase
            run_next = ctrl.cell_free ? run_inc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        acc_reg   <= acc_next;
        start_reg <= start_next;
    end

    assign acc   = acc_reg;
    assign found = found_reg;
    assign start = start_reg;
endmodule

/* src/contiguous_cell_allocator_core.sv */
// A refused allocate takes one scan over the n = cells_in_use cells; a placed one takes three
// or four scans plus a write pass over the placed cells; free takes two scans (one for owner
// zero). Throughput: one cell memory read per cycle per scan. A finished result waits in an
// output register while the next item is accepted. After reset, and after a cells_in_use
// write, a clearing pass over all CELLS cells runs before the first item is accepted.
module contiguous_cell_allocator_core #(
    parameter int CELLS   = ccal_pkg::CELLS_DEF,
    parameter int ID_BITS = ccal_pkg::ID_BITS_DEF,
    localparam int CW     = $clog2(CELLS + 1),
    localparam int CFG_W  = (CW > ccal_pkg::POL_W) ? CW : ccal_pkg::POL_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ccal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    ccal_req_if.sink                       req,
    ccal_rsp_if.source                     rsp
);
    import ccal_pkg::*;

    localparam int CB = $clog2(CELLS);
    localparam logic [CW-1:0] CELLS_W = CW'(CELLS);
    localparam logic [CW-1:0] LAST_W  = CW'(CELLS - 1);
    localparam logic [CW-1:0] ONE_W   = CW'(1);

    // Sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LARG1 = 4'd2;
    localparam logic [3:0] S_SMALL = 4'd3;
    localparam logic [3:0] S_PLACE = 4'd4;
    localparam logic [3:0] S_WRITE = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_LARG2 = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // Control registers
    logic [3:0]        state_reg, state_next;
    logic [POL_W-1:0]  policy_reg, policy_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     addr_reg, addr_next;
    logic              iss_done_reg, iss_done_next;
    logic              dv_reg, dv_next;
    logic              pass_done_reg, pass_done_next;
    logic              wrap_reg, wrap_next;
    logic [CB-1:0]     last_start_reg, last_start_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [RUNS_W-1:0] runs_reg, runs_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Payload registers
    logic [CW-1:0]       dpos_reg, dpos_next;
    logic                dvirt_reg, dvirt_next;
    logic                kind_reg;
    logic [ID_BITS-1:0]  owner_reg;
    logic [CW-1:0]       len_reg;
    logic [CW-1:0]       cleared_reg, cleared_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CB-1:0]       start_reg, start_next;
    logic [CW-1:0]       end_reg, end_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [CB-1:0]       rsp_start_reg;
    logic [CW-1:0]       rsp_largest_reg;
    logic [CW-1:0]       rsp_occ_reg;
    logic [CW-1:0]       rsp_runs_reg;

    // Memory and scan unit hookup
    logic               wr_en;
    logic [CB-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic               rd_en;
    logic [ID_BITS-1:0] rd_data;
    scan_ctrl_t         scan_ctrl;
    logic [CW-1:0]      scan_acc;
    logic               scan_found;
    logic [CB-1:0]      scan_start;

    // Sequencer helpers
    logic          accept;
    logic          rsp_load;
    logic          in_scan;
    logic          issue;
    logic          match;
    logic          go;
    logic [3:0]    go_state;
    logic          go_clr_acc;
    logic [CW-1:0] go_from;
    logic [CW-1:0] cfg_cells;

    assign accept  = req.valid && req.ready;
    assign in_scan = (state_reg == S_LARG1) || (state_reg == S_SMALL) ||
                     (state_reg == S_PLACE) || (state_reg == S_FREE) ||
                     (state_reg == S_LARG2);
    assign match   = dv_reg && !dvirt_reg && (rd_data == owner_reg);

    // Saturate a written managed-cell count to 1..CELLS
    always_comb
    begin
        cfg_cells = cfg_data[CW-1:0];
        if (cfg_cells == '0)
        begin
            cfg_cells = ONE_W;
        end
        else if (cfg_cells > CELLS_W)
        begin
            cfg_cells = CELLS_W;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        n_next          = n_reg;
        addr_next       = addr_reg;
        iss_done_next   = iss_done_reg;
        dv_next         = 1'b0;
        dpos_next       = dpos_reg;
        dvirt_next      = dvirt_reg;
        pass_done_next  = 1'b0;
        wrap_next       = wrap_reg;
        last_start_next = last_start_reg;
        occ_next        = occ_reg;
        runs_next       = runs_reg;
        cleared_next    = cleared_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_load        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = addr_reg[CB-1:0];
        wr_data         = '0;
        go              = 1'b0;
        go_state        = state_reg;
        go_clr_acc      = 1'b0;
        go_from         = '0;

        // Stream cells start..n-1 (start is 0 but for next fit) plus one virtual occupied cell at n
        issue = in_scan && !iss_done_reg;
        rd_en = issue && (addr_reg != n_reg);
        if (issue)
        begin
            dv_next    = 1'b1;
            dpos_next  = addr_reg;
            dvirt_next = (addr_reg == n_reg);
            if (addr_reg == n_reg)
            begin
                iss_done_next = 1'b1;
            end
            else
            begin
                addr_next = addr_reg + ONE_W;
            end
        end
        if (in_scan && dv_reg && dvirt_reg)
        begin
            pass_done_next = 1'b1;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_W)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ONE_W;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    start_next  = '0;
                    go          = 1'b1;
                    if (req.kind == KIND_ALLOC)
                    begin
                        go_state   = S_LARG1;
                        go_clr_acc = 1'b1;
                    end
                    else if (req.owner_id == '0)
                    begin
                        status_next = STATUS_NOT_FOUND;
                        go_state    = S_LARG2;
                        go_clr_acc  = 1'b1;
                    end
                    else
                    begin
                        cleared_next = '0;
                        go_state     = S_FREE;
                    end
                end
            end
            S_LARG1:
            begin
                if (pass_done_reg)
                begin
                    go        = 1'b1;
                    wrap_next = 1'b0;
                    if ((owner_reg == '0) || (len_reg == '0) || (len_reg > scan_acc))
                    begin
                        status_next = STATUS_REFUSED;
                        go_state    = S_DONE;
                    end
                    else
                    begin
                        case (policy_reg)
                            POL_FIRST: go_state = S_PLACE;
                            POL_NEXT:
                            begin
                                go_state = S_PLACE;
                                go_from  = CW'(last_start_reg) + ONE_W;
                            end
                            POL_BEST:  go_state = S_SMALL;
                            POL_WORST: go_state = S_PLACE;
                            default:   go_state = S_PLACE;
                        endcase
                    end
                end
            end
            S_SMALL:
            begin
                if (pass_done_reg)
                begin
                    go       = 1'b1;
                    go_state = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (scan_found)
                begin
                    start_next = scan_start;
                    end_next   = CW'(scan_start) + len_reg - ONE_W;
                    go         = 1'b1;
                    go_state   = S_WRITE;
                    go_from    = CW'(scan_start);
                end
                else if (pass_done_reg)
                begin
                    go = 1'b1;
                    if ((policy_reg == POL_NEXT) && !wrap_reg)
                    begin
                        wrap_next = 1'b1;
                        go_state  = S_PLACE;
                    end
                    else
                    begin
                        status_next = STATUS_REFUSED;
                        start_next  = '0;
                        go_state    = S_DONE;
                    end
                end
            end
            S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = owner_reg;
                if (addr_reg == end_reg)
                begin
                    last_start_next = start_reg;
                    occ_next        = occ_reg + len_reg;
                    runs_next       = runs_reg + RUNS_W'(1);
                    go              = 1'b1;
                    go_state        = S_LARG2;
                    go_clr_acc      = 1'b1;
                end
                else
                begin
                    addr_next = addr_reg + ONE_W;
                end
            end
            S_FREE:
            begin
                // Read-modify-write: clear the cell just read back
                wr_addr = dpos_reg[CB-1:0];
                if (match)
                begin
                    wr_en        = 1'b1;
                    cleared_next = cleared_reg + ONE_W;
                end
                if (pass_done_reg)
                begin
                    if (cleared_reg != '0)
                    begin
                        if (runs_reg != '0)
                        begin
                            runs_next = runs_reg - RUNS_W'(1);
                        end
                        occ_next = (occ_reg > cleared_reg) ? occ_reg - cleared_reg : '0;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                    go         = 1'b1;
                    go_state   = S_LARG2;
                    go_clr_acc = 1'b1;
                end
            end
            S_LARG2:
            begin
                if (pass_done_reg)
                begin
                    go       = 1'b1;
                    go_state = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Enter a new phase: restart the cell stream
        if (go)
        begin
            state_next     = go_state;
            addr_next      = go_from;
            iss_done_next  = 1'b0;
            dv_next        = 1'b0;
            pass_done_next = 1'b0;
        end

        // Configuration writes
        if (cfg_we)
        begin
            if (cfg_index == REG_FIT_POLICY)
            begin
                policy_next = cfg_data[POL_W-1:0];
            end
            else if (cfg_index == REG_CELLS_IN_USE)
            begin
                n_next          = cfg_cells;
                last_start_next = '0;
                occ_next        = '0;
                runs_next       = '0;
                state_next      = S_CLEAR;
                addr_next       = '0;
                dv_next         = 1'b0;
                pass_done_next  = 1'b0;
            end
        end
    end

    // Scan unit control
    always_comb
    begin
        scan_ctrl.init      = go && ((go_state == S_LARG1) || (go_state == S_SMALL) ||
                                     (go_state == S_PLACE) || (go_state == S_LARG2));
        scan_ctrl.clr_acc   = go_clr_acc;
        scan_ctrl.step      = dv_reg && in_scan && (state_reg != S_FREE);
        scan_ctrl.cell_free = !dvirt_reg && (rd_data == '0);
        case (state_reg)
            S_SMALL: scan_ctrl.mode = SM_SMALLEST;
            S_PLACE: scan_ctrl.mode = ((policy_reg == POL_FIRST) || (policy_reg == POL_NEXT)) ?
                                      SM_RUN : SM_HOLE;
            default: scan_ctrl.mode = SM_LARGEST;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            policy_reg     <= POL_FIRST;
            n_reg          <= CELLS_W;
            addr_reg       <= '0;
            iss_done_reg   <= 1'b0;
            dv_reg         <= 1'b0;
            pass_done_reg  <= 1'b0;
            wrap_reg       <= 1'b0;
            last_start_reg <= '0;
            occ_reg        <= '0;
            runs_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            n_reg          <= n_next;
            addr_reg       <= addr_next;
            iss_done_reg   <= iss_done_next;
            dv_reg         <= dv_next;
            pass_done_reg  <= pass_done_next;
            wrap_reg       <= wrap_next;
            last_start_reg <= last_start_next;
            occ_reg        <= occ_next;
            runs_reg       <= runs_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dpos_reg    <= dpos_next;
        dvirt_reg   <= dvirt_next;
        cleared_reg <= cleared_next;
        status_reg  <= status_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        if (accept)
        begin
            kind_reg  <= req.kind;
            owner_reg <= req.owner_id;
            len_reg   <= req.run_length;
        end
        if (rsp_load)
        begin
            rsp_status_reg  <= status_reg;
            rsp_start_reg   <= start_reg;
            rsp_largest_reg <= scan_acc;
            rsp_occ_reg     <= occ_reg;
            rsp_runs_reg    <= runs_reg[CW-1:0];
        end
    end

    ccal_store #(
        .CELLS   (CELLS),
        .ID_BITS (ID_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[CB-1:0]),
        .rd_data (rd_data)
    );

    ccal_scan #(
        .CELLS (CELLS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .pos   (dpos_reg),
        .len   (len_reg),
        .acc   (scan_acc),
        .found (scan_found),
        .start (scan_start)
    );

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.start_cell     = rsp_start_reg;
    assign rsp.largest_hole   = rsp_largest_reg;
    assign rsp.occupied_cells = rsp_occ_reg;
    assign rsp.owner_count    = rsp_runs_reg;

    // Placement never writes past the managed cells
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (addr_reg < n_reg))
        else $error("placement write beyond managed cells");

    // Held cell count stays within the managed cells
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= n_reg))
        else $error("occupied count exceeds managed cells");

    // An accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we) |=> !req.ready)
        else $error("ready while an item is in work");

    // A found run fits inside the managed cells
    a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE && scan_found) |->
        ((CW'(scan_start) + len_reg) <= n_reg))
        else $error("placed run overruns managed cells");

    // A refused allocation reports no start cell
    a_refused_start: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && status_reg == STATUS_REFUSED && kind_reg == KIND_ALLOC) |->
        (start_reg == '0))
        else $error("refused allocation with nonzero start");
endmodule
